/* hw/rtl/rpap_pkg.sv */
// ----------------------------------------------------------------------------
// rpap_pkg: shared types and constants for the pivot rotation block
// Holds coordinate defaults, register indexes and the quarter-wave sine
// table generator, which is evaluated only at elaboration.
// ----------------------------------------------------------------------------
package rpap_pkg;

   localparam int COORD_BITS_DEF     = 16;
   localparam int TRIG_FRAC_BITS_DEF = 15;
   localparam int ANGLE_BITS         = 9;
   localparam int CSR_ADDR_BITS      = 2;
   localparam int QUARTER_DEG        = 90;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ANGLE   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PIVOT_X = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PIVOT_Y = 2'd2;

   localparam longint unsigned PI_Q60        = 64'h3243F6A8885A308D;
   localparam longint unsigned DEG_HALF_TURN = 64'd180;
   localparam longint unsigned LOW32         = 64'hFFFF_FFFF;
   localparam longint unsigned ANGLE_STEP    = PI_Q60 / DEG_HALF_TURN;

   // (2n)(2n+1) for the Taylor terms n = 1..12
   localparam longint unsigned TAYLOR_DIV [1:12] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   // sin(k deg) for k = 0..90, unsigned, at most 2^frac_bits
   typedef logic [31:0] sine_tab_type [0:QUARTER_DEG];

   // (a*b) >> 60 for Q60 operands below 2^61
   function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
      longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
      al  = a & LOW32;
      ah  = a >> 32;
      bl  = b & LOW32;
      bh  = b >> 32;
      ll  = al * bl;
      lh  = al * bh;
      hl  = ah * bl;
      hh  = ah * bh;
      mid = (ll >> 32) + (lh & LOW32) + (hl & LOW32);
      lo  = (mid << 32) | (ll & LOW32);
      hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
      return (hi << 4) | (lo >> 60);
   endfunction

   // quarter-wave table rounded half up to frac_bits fraction bits
   function automatic sine_tab_type build_sine_tab(int frac_bits);
      sine_tab_type    tab;
      longint unsigned x, x2, term, sum, rnd;
      for (int k = 0; k <= QUARTER_DEG; k++) begin
         x    = ANGLE_STEP * longint'(k);
         x2   = mul_q60(x, x);
         term = x;
         sum  = x;
         for (int n = 1; n <= 12; n++) begin
            term = mul_q60(term, x2) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         rnd    = (sum + (64'd1 << (59 - frac_bits))) >> (60 - frac_bits);
         tab[k] = rnd[31:0];
      end
      return tab;
   endfunction

endpackage

/* hw/rtl/rotate_point_about_pivot.sv */
// ----------------------------------------------------------------------------
// rotate_point_about_pivot: rotate a 2D vertex about a configured pivot
// Six-stage pipeline: angle split, trig lookup and offsets, products,
// sums, truncation toward zero, pivot add with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one vertex per item (point_x, point_y). rsp_* returns one
//   rotated vertex per item, in order, with clipped on rsp_tuser when either
//   coordinate hit the range limit.
//   csr_* writes angle_degrees (index 0), pivot_x (1) and pivot_y (2); any
//   other index is ignored. Write only while no item is in flight.
//   Angles 360..511 wrap modulo 360.
// Path: an item passes stages 1 to 5 and the output register to rsp_tvalid.
// Throughput: one item per cycle unless rsp_tready stalls; each stage holds
//   one item, set by the 17x17 products and sum / truncate / saturate chain.
// Reset: clears all valid bits and the three registers to zero.
// Stall: when rsp_tready is low, items pile up in empty stages behind the
//   output register; req_tready drops only once every stage is full. No
//   item is lost or repeated.
// ----------------------------------------------------------------------------
module rotate_point_about_pivot
   import rpap_pkg::*;
#(
   parameter int  COORD_BITS     = COORD_BITS_DEF,
   parameter int  TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
   localparam int CsrW = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS,
   localparam int ReqW = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // point_x [COORD_BITS-1:0], point_y above it, zero padded to bytes
   input  logic [ReqW-1:0]          req_tdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // rotated_x [COORD_BITS-1:0], rotated_y above it, zero padded to bytes
   output logic [ReqW-1:0]          rsp_tdata,
   // clipped [0]
   output logic                     rsp_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_wen,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CsrW-1:0]          csr_wdata
);

   localparam int C   = COORD_BITS;
   localparam int F   = TRIG_FRAC_BITS;
   localparam int DW  = C + 1;       // pivot offset
   localparam int KW  = F + 2;       // signed trig coefficient
   localparam int PW  = DW + KW;     // one product
   localparam int SW  = PW + 1;      // sum of two products
   localparam int QW  = SW - F;      // truncated quotient
   localparam int NW  = QW + 1;      // quotient plus pivot

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam sine_tab_type SIN_TAB = build_sine_tab(F);

   localparam logic signed [NW-1:0] CMAX = {{(NW-C+1){1'b0}}, {(C-1){1'b1}}};
   localparam logic signed [NW-1:0] CMIN = {{(NW-C+1){1'b1}}, {(C-1){1'b0}}};

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [ANGLE_BITS-1:0] angle_ff;
   logic signed [C-1:0]   pivot_x_ff;
   logic signed [C-1:0]   pivot_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff   <= '0;
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_ANGLE:   angle_ff   <= csr_wdata[ANGLE_BITS-1:0];
            CSR_PIVOT_X: pivot_x_ff <= csr_wdata[C-1:0];
            CSR_PIVOT_Y: pivot_y_ff <= csr_wdata[C-1:0];
            default: ;   // drop writes to unknown indexes
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Stall chain: a stage takes a new item when it is empty or its
   // successor moves this cycle.
   // ------------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

   assign rdy_o      = !vo_ff || rsp_tready;
   assign rdy5       = !v5_ff || rdy_o;
   assign rdy4       = !v4_ff || rdy5;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy1)  v1_ff <= req_tvalid;
         if (rdy2)  v2_ff <= v1_ff;
         if (rdy3)  v3_ff <= v2_ff;
         if (rdy4)  v4_ff <= v3_ff;
         if (rdy5)  v5_ff <= v4_ff;
         if (rdy_o) vo_ff <= v5_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: capture the vertex, wrap the angle and split it into a
   // quadrant and a remainder below 90 degrees.
   // ------------------------------------------------------------------------
   logic [ANGLE_BITS-1:0] ang_red;
   logic [1:0]            quad_in;
   logic [6:0]            rem_in;
   logic [ANGLE_BITS-1:0] rem_wide;
   logic [1:0]            quad_s1_ff;
   logic [6:0]            rem_s1_ff;
   logic signed [C-1:0]   x_s1_ff, y_s1_ff;

   always_comb begin
      ang_red = (angle_ff >= 9'd360) ? angle_ff - 9'd360 : angle_ff;
      if (ang_red >= 9'd270) begin
         quad_in  = QUAD_3;
         rem_wide = ang_red - 9'd270;
      end else if (ang_red >= 9'd180) begin
         quad_in  = QUAD_2;
         rem_wide = ang_red - 9'd180;
      end else if (ang_red >= 9'd90) begin
         quad_in  = QUAD_1;
         rem_wide = ang_red - 9'd90;
      end else begin
         quad_in  = QUAD_0;
         rem_wide = ang_red;
      end
      rem_in = rem_wide[6:0];
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         quad_s1_ff <= quad_in;
         rem_s1_ff  <= rem_in;
         x_s1_ff    <= req_tdata[C-1:0];
         y_s1_ff    <= req_tdata[2*C-1:C];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: look up sine and cosine, fold in the quadrant signs, and
   // form the offsets from the pivot.
   // ------------------------------------------------------------------------
   logic [31:0]          sr_raw, cr_raw;
   logic signed [KW-1:0] sr, cr, s_in, c_in;
   logic signed [KW-1:0] s_s2_ff, c_s2_ff;
   logic signed [DW-1:0] dx_s2_ff, dy_s2_ff;

   always_comb begin
      sr_raw = SIN_TAB[rem_s1_ff];
      cr_raw = SIN_TAB[7'(QUARTER_DEG) - rem_s1_ff];
      sr     = sr_raw[KW-1:0];
      cr     = cr_raw[KW-1:0];
      case (quad_s1_ff)
         QUAD_0: begin s_in = sr;  c_in = cr;  end
         QUAD_1: begin s_in = cr;  c_in = -sr; end
         QUAD_2: begin s_in = -sr; c_in = -cr; end
         QUAD_3: begin s_in = -cr; c_in = sr;  end
         default: begin s_in = sr; c_in = cr;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s_s2_ff  <= s_in;
         c_s2_ff  <= c_in;
         dx_s2_ff <= DW'(x_s1_ff) - DW'(pivot_x_ff);
         dy_s2_ff <= DW'(y_s1_ff) - DW'(pivot_y_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: four products, one multiplier each
   // ------------------------------------------------------------------------
   logic signed [PW-1:0] cdx_s3_ff, sdy_s3_ff, cdy_s3_ff, sdx_s3_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         cdx_s3_ff <= PW'(c_s2_ff) * PW'(dx_s2_ff);
         sdy_s3_ff <= PW'(s_s2_ff) * PW'(dy_s2_ff);
         cdy_s3_ff <= PW'(c_s2_ff) * PW'(dy_s2_ff);
         sdx_s3_ff <= PW'(s_s2_ff) * PW'(dx_s2_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: exact sums
   // ------------------------------------------------------------------------
   logic signed [SW-1:0] sumx_s4_ff, sumy_s4_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         sumx_s4_ff <= SW'(cdx_s3_ff) + SW'(sdy_s3_ff);
         sumy_s4_ff <= SW'(cdy_s3_ff) - SW'(sdx_s3_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: divide by 2^F, rounding toward zero (bias negatives first)
   // ------------------------------------------------------------------------
   logic signed [SW-1:0] biasx, biasy, tx, ty;
   logic signed [QW-1:0] qx_s5_ff, qy_s5_ff;

   always_comb begin
      biasx = {{(SW-F){1'b0}}, {F{sumx_s4_ff[SW-1]}}};
      biasy = {{(SW-F){1'b0}}, {F{sumy_s4_ff[SW-1]}}};
      tx    = sumx_s4_ff + biasx;
      ty    = sumy_s4_ff + biasy;
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         qx_s5_ff <= tx[SW-1:F];
         qy_s5_ff <= ty[SW-1:F];
      end
   end

   // ------------------------------------------------------------------------
   // Output stage: add the pivot back and saturate to the coordinate range
   // ------------------------------------------------------------------------
   logic signed [NW-1:0] nx, ny;
   logic [C-1:0]         rx_in, ry_in;
   logic                 clip_in;
   logic [C-1:0]         rx_ff, ry_ff;
   logic                 clip_ff;

   always_comb begin
      nx      = NW'(qx_s5_ff) + NW'(pivot_x_ff);
      ny      = NW'(qy_s5_ff) + NW'(pivot_y_ff);
      clip_in = 1'b0;
      if (nx > CMAX) begin
         rx_in   = CMAX[C-1:0];
         clip_in = 1'b1;
      end else if (nx < CMIN) begin
         rx_in   = CMIN[C-1:0];
         clip_in = 1'b1;
      end else begin
         rx_in = nx[C-1:0];
      end
      if (ny > CMAX) begin
         ry_in   = CMAX[C-1:0];
         clip_in = 1'b1;
      end else if (ny < CMIN) begin
         ry_in   = CMIN[C-1:0];
         clip_in = 1'b1;
      end else begin
         ry_in = ny[C-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_o) begin
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_tdata  = ReqW'({ry_ff, rx_ff});
   assign rsp_tuser  = clip_ff;
   assign rsp_tvalid = vo_ff;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rotate_point_about_pivot
// Streams vertices through the block under several angle and pivot settings
// and compares every rotated vertex with its typed result or a bit-exact
// fixed-point predictor with its own quarter-wave sine table. Both stream
// sides idle and stall at random; settings change only on an empty pipeline.
// ----------------------------------------------------------------------------
module tb_top;
   import rpap_pkg::*;

   localparam int              FRAC_BITS   = TRIG_FRAC_BITS_DEF;
   localparam longint          FRAC_ONE    = 64'sd1 << FRAC_BITS;
   localparam longint unsigned PI_FIX60    = 64'h3243_F6A8_885A_308D;
   localparam int              STALL_LIMIT = 2000;
   localparam int              PHASES      = 14;
   localparam int              PHASE_ITEMS = 110;
   localparam shortint         CMAX        = 16'sh7FFF;
   localparam shortint         CMIN        = 16'sh8000;
   // index 3 decodes to nothing; writes there must leave the registers alone
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNMAPPED = 2'd3;

   // one rotated vertex as it comes back on the result stream
   typedef struct packed {
      shortint x;
      shortint y;
      logic    clip;
   } vertex_out_type;

   // directed stimulus: optional new settings, one vertex, optional typed result
   typedef struct packed {
      logic        load;
      logic [15:0] angle_wr;
      shortint     piv_x;
      shortint     piv_y;
      shortint     pt_x;
      shortint     pt_y;
      logic        known;
      shortint     exp_x;
      shortint     exp_y;
      logic        exp_clip;
   } vec_row_type;

   localparam vec_row_type DIRECTED_ROWS [0:23] = '{
      // settings straight out of reset: identity
      '{1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b0},
      '{1'b0, 16'd0, 16'sd0, 16'sd0, CMAX, CMIN, 1'b1, CMAX, CMIN, 1'b0},
      '{1'b0, 16'd0, 16'sd0, 16'sd0, CMIN, CMAX, 1'b1, CMIN, CMAX, 1'b0},
      // quarter turns are exact swaps and negations
      '{1'b1, 16'd90, 16'sd0, 16'sd0, 16'sd100, 16'sd200, 1'b1, 16'sd200, -16'sd100, 1'b0},
      '{1'b0, 16'd90, 16'sd0, 16'sd0, CMIN, CMAX, 1'b1, CMAX, CMAX, 1'b1},
      '{1'b1, 16'd180, 16'sd0, 16'sd0, CMIN, 16'sd5, 1'b1, CMAX, -16'sd5, 1'b1},
      '{1'b0, 16'd180, 16'sd0, 16'sd0, CMAX, -16'sd32767, 1'b1, -16'sd32767, CMAX, 1'b0},
      '{1'b1, 16'd270, 16'sd0, 16'sd0, CMIN, CMIN, 1'b1, CMAX, CMIN, 1'b1},
      // pivot at the range corners: saturate high, saturate low, pivot itself
      '{1'b1, 16'd180, CMAX, CMAX, CMIN, CMIN, 1'b1, CMAX, CMAX, 1'b1},
      '{1'b1, 16'd180, CMIN, CMIN, CMAX, CMAX, 1'b1, CMIN, CMIN, 1'b1},
      '{1'b0, 16'd180, CMIN, CMIN, CMIN, CMIN, 1'b1, CMIN, CMIN, 1'b0},
      // angles past 359 wrap; bits above the angle field are dropped
      '{1'b1, 16'd360, 16'sd0, 16'sd0, 16'sd1234, -16'sd4321, 1'b1,
        16'sd1234, -16'sd4321, 1'b0},
      '{1'b1, 16'hFE00, 16'sd0, 16'sd0, -16'sd1, 16'sd1, 1'b1, -16'sd1, 16'sd1, 1'b0},
      '{1'b1, 16'hFFFF, 16'sd0, 16'sd0, 16'sd20000, -16'sd20000, 1'b0,
        16'sd0, 16'sd0, 1'b0},
      // odd angles, every quadrant, truncation toward zero
      '{1'b1, 16'd45, 16'sd100, -16'sd100, CMAX, CMAX, 1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b0, 16'd45, 16'sd100, -16'sd100, CMIN, CMIN, 1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 16'd1, 16'sd0, 16'sd0, CMAX, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 16'd89, 16'sd0, 16'sd0, 16'sd0, CMAX, 1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 16'd91, 16'sd0, 16'sd0, CMIN, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 16'd359, CMIN, CMAX, CMAX, CMIN, 1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 16'd450, 16'sd1000, -16'sd1000, 16'sd1000, -16'sd1000, 1'b1,
        16'sd1000, -16'sd1000, 1'b0},
      '{1'b1, 16'd135, 16'sd0, 16'sd0, -16'sd12345, 16'sd23456, 1'b0,
        16'sd0, 16'sd0, 1'b0},
      '{1'b1, 16'd225, 16'sd0, 16'sd0, 16'sd1, -16'sd1, 1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 16'd315, 16'sd0, 16'sd0, -16'sd1, -16'sd1, 1'b0, 16'sd0, 16'sd0, 1'b0}
   };

   logic                     clock;
   logic                     reset;
   logic [31:0]              req_tdata;   // point_x [15:0], point_y [31:16]
   logic                     req_tvalid;
   logic                     req_tready;
   logic [31:0]              rsp_tdata;   // rotated_x [15:0], rotated_y [31:16]
   logic                     rsp_tuser;   // clipped [0]
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic                     csr_wen;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [15:0]              csr_wdata;

   // shadow copy of the block's settings, updated as they are written
   logic [ANGLE_BITS-1:0] cfg_angle;
   shortint               cfg_pivot_x;
   shortint               cfg_pivot_y;

   longint         sine_q15 [0:QUARTER_DEG];
   vertex_out_type pending_vertices [$];
   int             mismatches;
   logic           burst_mode;   // both sides run without idle cycles

   rotate_point_about_pivot dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // bits 60..123 of the full 128-bit product
   function automatic longint unsigned fx_mul60(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[123:60];
   endfunction

   // sin(k deg) by a 13-term Taylor series in Q60, rounded half up to Q15
   function automatic longint sin_deg_q15(int k);
      longint unsigned x, x2, term, sum;
      x    = (PI_FIX60 / 64'd180) * 64'(k);
      x2   = fx_mul60(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= 12; n++) begin
         term = fx_mul60(term, x2) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return longint'((sum + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
   endfunction

   function automatic shortint clamp_coord(longint v, inout logic hit);
      if (v > longint'(CMAX)) begin
         hit = 1'b1;
         return CMAX;
      end
      if (v < longint'(CMIN)) begin
         hit = 1'b1;
         return CMIN;
      end
      return shortint'(v);
   endfunction

   function automatic vertex_out_type rotate_vertex(shortint x, shortint y);
      int             ang, quad, rem;
      longint         s, c, dx, dy, nx, ny;
      vertex_out_type r;
      ang  = int'(cfg_angle) % 360;
      quad = ang / 90;
      rem  = ang % 90;
      // fold the angle into the first quadrant and fix signs by symmetry
      case (quad)
         0: begin
            s = sine_q15[rem];
            c = sine_q15[90 - rem];
         end
         1: begin
            s = sine_q15[90 - rem];
            c = -sine_q15[rem];
         end
         2: begin
            s = -sine_q15[rem];
            c = -sine_q15[90 - rem];
         end
         default: begin
            s = -sine_q15[90 - rem];
            c = sine_q15[rem];
         end
      endcase
      dx = longint'(x) - longint'(cfg_pivot_x);
      dy = longint'(y) - longint'(cfg_pivot_y);
      // exact sums, one division that truncates toward zero
      nx = longint'(cfg_pivot_x) + (c * dx + s * dy) / FRAC_ONE;
      ny = longint'(cfg_pivot_y) + (c * dy - s * dx) / FRAC_ONE;
      r.clip = 1'b0;
      r.x    = clamp_coord(nx, r.clip);
      r.y    = clamp_coord(ny, r.clip);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // random, or at extreme_pct percent odds a range corner, zero or minus one
   function automatic shortint pick_coord(int extreme_pct);
      if ($urandom_range(0, 99) < extreme_pct) begin
         case ($urandom_range(0, 3))
            0:       return CMIN;
            1:       return CMAX;
            2:       return 16'sd0;
            default: return -16'sd1;
         endcase
      end
      return shortint'($urandom);
   endfunction

   // hold valid low and wait until every pending vertex has come back
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
   endtask

   // one write per cycle, then a junk write to the unmapped index
   task automatic load_config(input logic [15:0] angle_wr, input shortint px,
                              input shortint py);
      logic [CSR_ADDR_BITS-1:0] addrs [0:3];
      logic [15:0]              words [0:3];
      addrs = '{CSR_ANGLE, CSR_PIVOT_X, CSR_PIVOT_Y, CSR_UNMAPPED};
      words = '{angle_wr, 16'(px), 16'(py), 16'($urandom)};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_wen   <= 1'b1;
         csr_addr  <= addrs[i];
         csr_wdata <= words[i];
         @(posedge clock);
      end
      @(negedge clock);
      csr_wen     <= 1'b0;
      cfg_angle   = angle_wr[ANGLE_BITS-1:0];
      cfg_pivot_x = px;
      cfg_pivot_y = py;
   endtask

   // offer one vertex after a random gap and log its expected result
   task automatic send_point(input shortint x, input shortint y, input logic typed,
                             input vertex_out_type typed_out);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
      pending_vertices.push_back(typed ? typed_out : rotate_vertex(x, y));
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      vec_row_type    row;
      vertex_out_type typed_out;
      logic [15:0]    ang_wr;
      shortint        px, py, x, y;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wen     = 1'b0;
      csr_addr    = CSR_ANGLE;
      csr_wdata   = '0;
      cfg_angle   = '0;
      cfg_pivot_x = 16'sd0;
      cfg_pivot_y = 16'sd0;
      mismatches  = 0;
      burst_mode  = 1'b0;
      for (int k = 0; k <= QUARTER_DEG; k++) sine_q15[k] = sin_deg_q15(k);

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed rows: new settings only on an empty pipeline
      for (int i = 0; i <= 23; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.load) begin
            drain_pipeline();
            load_config(row.angle_wr, row.piv_x, row.piv_y);
         end
         typed_out = '{row.exp_x, row.exp_y, row.exp_clip};
         send_point(row.pt_x, row.pt_y, row.known, typed_out);
      end

      // random phases, each with fresh settings and its own idling mode
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_pipeline();
         burst_mode = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0:       ang_wr = 16'd0;
            1:       ang_wr = 16'd359;
            2:       ang_wr = 16'($urandom_range(360, 511));
            3:       ang_wr = 16'(90 * $urandom_range(0, 3));
            default: ang_wr = 16'($urandom);
         endcase
         px = pick_coord(25);
         py = pick_coord(25);
         load_config(ang_wr, px, py);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  // close to the pivot, where truncation matters most
                  x = shortint'(int'(cfg_pivot_x) + int'($urandom_range(0, 600)) - 300);
                  y = shortint'(int'(cfg_pivot_y) + int'($urandom_range(0, 600)) - 300);
               end
               2, 3: begin
                  x = pick_coord(100);
                  y = pick_coord(100);
               end
               default: begin
                  x = pick_coord(0);
                  y = pick_coord(0);
               end
            endcase
            send_point(x, y, 1'b0, '0);
         end
      end

      // drain, then give stray items time to surface
      drain_pipeline();
      repeat (24) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // result side: random stall after each accepted item, none in burst mode
   initial begin
      int hold;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) hold = burst_mode ? 0 : $urandom_range(0, 5);
      end
   end

   // compare each accepted item with the oldest pending vertex
   always @(posedge clock) begin
      vertex_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch($sformatf("item with none pending: x=%0d y=%0d clipped=%b",
                                      $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]),
                                      rsp_tuser));
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_tdata[15:0] !== want.x)
               report_mismatch($sformatf("rotated_x exp %0d got %0d", want.x,
                                         $signed(rsp_tdata[15:0])));
            if (rsp_tdata[31:16] !== want.y)
               report_mismatch($sformatf("rotated_y exp %0d got %0d", want.y,
                                         $signed(rsp_tdata[31:16])));
            if (rsp_tuser !== want.clip)
               report_mismatch($sformatf("clipped exp %b got %b", want.clip, rsp_tuser));
         end
      end
   end

   // drop the run if nothing moves for too long
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

endmodule
